// ===== design/divider_and_timer_counter_top_macros.svh =====
// assertion macros for the divider and timer counter
// used by dtc_core and divider_and_timer_counter_top, expects clk_i and rst_ni in scope
`ifndef DIVIDER_AND_TIMER_COUNTER_TOP_MACROS_SVH
`define DIVIDER_AND_TIMER_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define DTC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtc_pkg.sv =====
// shared types, codes and period table for the divider and timer counter
// no dependencies
package dtc_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SEL_DIV  = 2'd0,
    SEL_TIMA = 2'd1,
    SEL_TMA  = 2'd2,
    SEL_TAC  = 2'd3
  } sel_e;

  localparam int unsigned TacEnableBit = 2;
  localparam logic [8:0]  DivLimit     = 9'd255;
  localparam logic [7:0]  TimaMax      = 8'hff;
  localparam logic signed [11:0] PeriodReset = 12'sd1024;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] cycles;
    sel_e       sel;
    logic [7:0] data;
  } dtc_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } dtc_result_t;

  function automatic logic signed [11:0] rate_period(input logic [1:0] rate);
    logic signed [11:0] p;
    case (rate)
      2'd0:    p = 12'sd1024;
      2'd1:    p = 12'sd16;
      2'd2:    p = 12'sd64;
      2'd3:    p = 12'sd256;
      default: p = 12'sd1024;
    endcase
    return p;
  endfunction

endpackage

// ===== design/divider_and_timer_counter_top.sv =====
// top level of the divider and timer counter: input register, core, result register
// depends on dtc_pkg, dtc_core and divider_and_timer_counter_top_macros.svh
//
// channel  | signals                                               | direction
// input    | in_valid_i, in_ready_o, command_i, cycles_i,          | in
//          | reg_select_i, write_data_i                            |
// output   | out_valid_o, out_ready_i, read_data_o, timer_irq_o    | out
//
// one transaction per cycle while the output is not stalled; input passes the input register, then the result register
// the input register feeds one pass through the core, whose state and result
// register load together, so consecutive transactions see updated state
// reset clears valids and timer state, down-counter restarts at 1024
// a stalled output holds the result and the input register behind it
`include "divider_and_timer_counter_top_macros.svh"

module divider_and_timer_counter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [7:0] cycles_i,
  input  logic [1:0] reg_select_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       timer_irq_o
);
  import dtc_pkg::*;

  logic        in_valid_q;
  dtc_item_t   item_q;
  logic        out_valid_q;
  dtc_result_t res_q;
  dtc_result_t core_res;
  logic        advance;
  logic        fire;
  logic        in_take;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd    <= cmd_e'(command_i);
      item_q.cycles <= cycles_i;
      item_q.sel    <= sel_e'(reg_select_i);
      item_q.data   <= write_data_i;
    end
  end

  dtc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = res_q.read_data;
  assign timer_irq_o = res_q.timer_irq;

  `DTC_ASSERT_NEXT(a_take_loads, in_take, in_valid_q, "accepted transaction not registered")
  `DTC_ASSERT_NEXT(a_fire_shows, fire, out_valid_q, "processed transaction has no result")
  `DTC_ASSERT_NOW(a_irq_no_data, out_valid_q && res_q.timer_irq, res_q.read_data == 8'd0, "irq with read data")

endmodule

// ===== design/dtc_core.sv =====
// divider and timer state registers with their single-pass update logic
// depends on dtc_pkg and divider_and_timer_counter_top_macros.svh
`include "divider_and_timer_counter_top_macros.svh"

module dtc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  dtc_pkg::dtc_item_t  item_i,
  output dtc_pkg::dtc_result_t res_o
);
  import dtc_pkg::*;

  logic [7:0]         div_q, div_d;
  logic [7:0]         div_cnt_q, div_cnt_d;
  logic [7:0]         tima_q, tima_d;
  logic [7:0]         tma_q, tma_d;
  logic [2:0]         tac_q, tac_d;
  logic signed [11:0] cyc_rem_q, cyc_rem_d;

  logic [8:0]         div_sum;
  logic signed [11:0] cyc_diff;
  dtc_result_t        res;

  assign div_sum  = {1'b0, div_cnt_q} + {1'b0, item_i.cycles};
  assign cyc_diff = cyc_rem_q - $signed({4'b0000, item_i.cycles});

  always_comb begin
    div_d         = div_q;
    div_cnt_d     = div_cnt_q;
    tima_d        = tima_q;
    tma_d         = tma_q;
    tac_d         = tac_q;
    cyc_rem_d     = cyc_rem_q;
    res.read_data = 8'd0;
    res.timer_irq = 1'b0;
    case (item_i.cmd)
      CMD_TICK: begin
        if (div_sum >= DivLimit) begin
          div_cnt_d = 8'd0;
          div_d     = div_q + 8'd1;
        end else begin
          div_cnt_d = div_sum[7:0];
        end
        if (tac_q[TacEnableBit]) begin
          if (cyc_diff[11] || (cyc_diff == 12'sd0)) begin
            cyc_rem_d = rate_period(tac_q[1:0]);
            if (tima_q == TimaMax) begin
              tima_d        = tma_q;
              res.timer_irq = 1'b1;
            end else begin
              tima_d = tima_q + 8'd1;
            end
          end else begin
            cyc_rem_d = cyc_diff;
          end
        end
      end
      CMD_WRITE: begin
        case (item_i.sel)
          SEL_DIV:  div_d  = 8'd0;
          SEL_TIMA: tima_d = item_i.data;
          SEL_TMA:  tma_d  = item_i.data;
          SEL_TAC: begin
            tac_d = item_i.data[2:0];
            if (item_i.data[1:0] != tac_q[1:0]) begin
              cyc_rem_d = rate_period(item_i.data[1:0]);
            end
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        case (item_i.sel)
          SEL_DIV:  res.read_data = div_q;
          SEL_TIMA: res.read_data = tima_q;
          SEL_TMA:  res.read_data = tma_q;
          SEL_TAC:  res.read_data = {5'd0, tac_q};
          default:  res.read_data = 8'd0;
        endcase
      end
      default: ;
    endcase
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q     <= 8'd0;
      div_cnt_q <= 8'd0;
      tima_q    <= 8'd0;
      tma_q     <= 8'd0;
      tac_q     <= 3'd0;
      cyc_rem_q <= PeriodReset;
    end else if (fire_i) begin
      div_q     <= div_d;
      div_cnt_q <= div_cnt_d;
      tima_q    <= tima_d;
      tma_q     <= tma_d;
      tac_q     <= tac_d;
      cyc_rem_q <= cyc_rem_d;
    end
  end

  `DTC_ASSERT_NOW(a_div_cnt_range, 1'b1, {1'b0, div_cnt_q} < DivLimit, "divider count out of range")
  `DTC_ASSERT_NOW(a_cyc_rem_range, 1'b1, (cyc_rem_q > 12'sd0) && (cyc_rem_q <= PeriodReset), "down-counter out of range")
  `DTC_ASSERT_NOW(a_irq_source, fire_i && res.timer_irq, (item_i.cmd == CMD_TICK) && tac_q[TacEnableBit] && (tima_q == TimaMax), "irq without timer overflow")

endmodule
